// ----- rtl/stx_len_crc_frame_parser_macros.svh -----
// assertion helpers for the frame parser
`ifndef STX_LEN_CRC_FRAME_PARSER_MACROS_SVH
`define STX_LEN_CRC_FRAME_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// overlapping implication, checked on every rising edge out of reset
`define STX_LCFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent checked in the cycle after the antecedent
`define STX_LCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define STX_LCFP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define STX_LCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/stx_lcfp_pkg.sv -----
package stx_lcfp_pkg;

    localparam int unsigned OUT_CNT_W = 32;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [7:0] START_RESET = 8'd2;
    localparam logic [7:0] END_RESET   = 8'd3;
    localparam logic [7:0] MAX_RESET   = 8'd64;

    typedef enum logic [1:0] {
        CFG_START_BYTE  = 2'd0,
        CFG_END_BYTE    = 2'd1,
        CFG_MAX_PAYLOAD = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LEN     = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CRC_LO  = 3'd3,
        PH_CRC_HI  = 3'd4,
        PH_END     = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_COMPLETE = 3'd1,
        EV_LENGTH   = 3'd2,
        EV_CRC      = 3'd3,
        EV_FRAMING  = 3'd4
    } t_event;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] frame_length;
        logic       payload_write;
        logic [7:0] payload_index;
        logic [7:0] payload_byte;
    } t_result;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] discarded;
        logic [OUT_CNT_W-1:0] length_error;
        logic [OUT_CNT_W-1:0] crc_error;
        logic [OUT_CNT_W-1:0] framing_error;
        logic [OUT_CNT_W-1:0] good_frame;
    } t_counts;

endpackage

// ----- rtl/stx_len_crc_frame_parser.sv -----
// framed byte stream parser: start byte, length, payload, crc low, crc high, end byte
// slave channel s_axis carries one received link byte per request
// master channel m_axis returns exactly one result per accepted byte:
//   the event code and payload write flag in tuser, frame length, payload echo
//   and the five wrapping error and frame counters in tdata
// configuration (start byte, end byte, max payload) is written through
// i_cfg_we / i_cfg_addr / i_cfg_data; the user must write it only while no byte
// is in flight, the block itself does not enforce it
// path: an accepted byte is held in the input register, then parsed into the
// result register, which drives m_axis; throughput: one byte per cycle while
// the output is free; the crc update is an eight step byte-wide crc-16 unroll
// reset: i_rst_n low at a clock edge clears both register stages, returns the
// parser to hunting for the start byte, zeroes the counters, and loads the
// configuration reset values 2, 3 and 64
// stall: with m_axis_tready low the result holds, one more byte is absorbed
// in the input register, then s_axis_tready drops
module stx_len_crc_frame_parser #(
    parameter int unsigned BUFFER_DEPTH  = 256,
    parameter int unsigned COUNTER_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [7:0]   i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // rx_byte[7:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // frame_length[7:0], payload_index[15:8], payload_byte[23:16],
    // discarded_count[55:24], length_error_count[87:56], crc_error_count[119:88],
    // framing_error_count[151:120], good_frame_count[183:152]
    output logic [183:0] m_axis_tdata,
    output logic [3:0]   m_axis_tuser    // event_res[2:0], payload_write[3]
);
    import stx_lcfp_pkg::*;

    logic    r_in_valid;
    logic [7:0] r_in_byte;
    logic    r_out_valid;
    t_result r_res;
    t_result res;
    t_counts counts;
    logic    out_free;
    logic    step;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    stx_lcfp_parser #(
        .BUFFER_DEPTH  (BUFFER_DEPTH),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_byte     (r_in_byte),
        .o_res      (res),
        .o_counts   (counts)
    );

    // counters live in the parser and only move when a new result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_res.payload_write, r_res.event_res};
    assign m_axis_tdata  = {counts.good_frame, counts.framing_error, counts.crc_error,
                            counts.length_error, counts.discarded, r_res.payload_byte,
                            r_res.payload_index, r_res.frame_length};

endmodule

// ----- rtl/stx_lcfp_crc8.sv -----
module stx_lcfp_crc8 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import stx_lcfp_pkg::*;

    // crc-16 msb first, one byte per pass, eight shift steps unrolled
    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

// ----- rtl/stx_lcfp_parser.sv -----
`include "stx_len_crc_frame_parser_macros.svh"

module stx_lcfp_parser #(
    parameter int unsigned BUFFER_DEPTH  = 256,
    parameter int unsigned COUNTER_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_addr,
    input  logic [7:0]             i_cfg_data,
    input  logic                   i_step,
    input  logic [7:0]             i_byte,
    output stx_lcfp_pkg::t_result  o_res,
    output stx_lcfp_pkg::t_counts  o_counts
);
    import stx_lcfp_pkg::*;

    localparam logic [8:0] DEPTH_LIMIT = 9'(BUFFER_DEPTH);
    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

    logic [7:0]  r_start;
    logic [7:0]  r_end;
    logic [7:0]  r_max;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [7:0]  r_len;
    logic [7:0]  n_len;
    logic [7:0]  r_pos;
    logic [7:0]  n_pos;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_rcv_lo;
    logic [7:0]  n_rcv_lo;

    logic [COUNTER_WIDTH-1:0] r_drop_cnt;
    logic [COUNTER_WIDTH-1:0] r_len_cnt;
    logic [COUNTER_WIDTH-1:0] r_crc_cnt;
    logic [COUNTER_WIDTH-1:0] r_end_cnt;
    logic [COUNTER_WIDTH-1:0] r_ok_cnt;

    logic        drop_hit;
    logic [15:0] crc_upd;
    logic [7:0]  pos_inc;
    logic        crc_ok;
    logic        len_bad;
    t_event      ev;

    stx_lcfp_crc8 u_crc8 (
        .i_crc  (r_crc),
        .i_byte (i_byte),
        .o_crc  (crc_upd)
    );

    assign pos_inc = r_pos + 8'd1;
    assign crc_ok  = ({i_byte, r_rcv_lo} == r_crc);
    assign len_bad = (i_byte > r_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RESET;
            r_end   <= END_RESET;
            r_max   <= MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_START_BYTE:  r_start <= i_cfg_data;
                CFG_END_BYTE:    r_end   <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_LEN: begin
                if (len_bad) begin
                    n_phase = PH_IDLE;
                end else if (i_byte == 8'd0) begin
                    n_phase = PH_CRC_LO;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (pos_inc >= r_len) begin
                    n_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: n_phase = PH_CRC_HI;
            PH_CRC_HI: n_phase = crc_ok ? PH_END : PH_IDLE;
            PH_END:    n_phase = PH_IDLE;
            default: begin
                if (i_byte == r_start) begin
                    n_phase = PH_LEN;
                end
            end
        endcase
    end

    // datapath and event for the byte in flight
    always_comb begin
        n_len    = r_len;
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_rcv_lo = r_rcv_lo;
        ev       = EV_NONE;
        drop_hit = 1'b0;
        o_res.payload_write = 1'b0;
        o_res.payload_index = 8'd0;
        o_res.payload_byte  = 8'd0;
        unique case (r_phase)
            PH_LEN: begin
                if (len_bad) begin
                    ev = EV_LENGTH;
                end else begin
                    n_len = i_byte;
                    n_crc = crc_upd;
                end
            end
            PH_PAYLOAD: begin
                if ({1'b0, r_pos} < DEPTH_LIMIT) begin
                    o_res.payload_write = 1'b1;
                    o_res.payload_index = r_pos;
                    o_res.payload_byte  = i_byte;
                end
                n_pos = pos_inc;
                n_crc = crc_upd;
            end
            PH_CRC_LO: n_rcv_lo = i_byte;
            PH_CRC_HI: begin
                if (!crc_ok) begin
                    ev = EV_CRC;
                end
            end
            PH_END: ev = (i_byte == r_end) ? EV_COMPLETE : EV_FRAMING;
            default: begin
                if (i_byte == r_start) begin
                    n_len = 8'd0;
                    n_pos = 8'd0;
                    n_crc = CRC_INIT;
                end else begin
                    drop_hit = 1'b1;
                end
            end
        endcase
        o_res.event_res    = ev;
        o_res.frame_length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_len    <= 8'd0;
            r_pos    <= 8'd0;
            r_crc    <= CRC_INIT;
            r_rcv_lo <= 8'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_rcv_lo <= n_rcv_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_cnt <= '0;
            r_len_cnt  <= '0;
            r_crc_cnt  <= '0;
            r_end_cnt  <= '0;
            r_ok_cnt   <= '0;
        end else if (i_step) begin
            if (drop_hit) begin
                r_drop_cnt <= r_drop_cnt + CNT_ONE;
            end
            if (ev == EV_LENGTH) begin
                r_len_cnt <= r_len_cnt + CNT_ONE;
            end
            if (ev == EV_CRC) begin
                r_crc_cnt <= r_crc_cnt + CNT_ONE;
            end
            if (ev == EV_FRAMING) begin
                r_end_cnt <= r_end_cnt + CNT_ONE;
            end
            if (ev == EV_COMPLETE) begin
                r_ok_cnt <= r_ok_cnt + CNT_ONE;
            end
        end
    end

    // counters are reported as their low bits, zero extended when narrower
    assign o_counts.discarded     = OUT_CNT_W'(r_drop_cnt);
    assign o_counts.length_error  = OUT_CNT_W'(r_len_cnt);
    assign o_counts.crc_error     = OUT_CNT_W'(r_crc_cnt);
    assign o_counts.framing_error = OUT_CNT_W'(r_end_cnt);
    assign o_counts.good_frame    = OUT_CNT_W'(r_ok_cnt);

    `STX_LCFP_ASSERT_NEXT(a_hold_when_idle, i_clk, i_rst_n, !i_step, $stable(r_phase) && $stable(r_crc) && $stable(r_ok_cnt))
    `STX_LCFP_ASSERT_NEXT(a_start_opens, i_clk, i_rst_n, i_step && r_phase == PH_IDLE && i_byte == r_start, r_phase == PH_LEN && r_crc == CRC_INIT && r_pos == 8'd0)
    `STX_LCFP_ASSERT_NEXT(a_end_closes, i_clk, i_rst_n, i_step && r_phase == PH_END, r_phase == PH_IDLE)
    `STX_LCFP_ASSERT_NEXT(a_good_counts, i_clk, i_rst_n, i_step && ev == EV_COMPLETE, r_ok_cnt != $past(r_ok_cnt))
    `STX_LCFP_ASSERT_SAME(a_write_in_payload, i_clk, i_rst_n, o_res.payload_write, r_phase == PH_PAYLOAD && ev == EV_NONE)

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import stx_lcfp_pkg::*;

    localparam int BUF_DEPTH    = 256;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 150;

    typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_END, FR_CUT} t_frame_kind;

    typedef struct packed {
        t_event      ev;
        logic [7:0]  flen;
        logic        wr;
        logic [7:0]  widx;
        logic [7:0]  wbyte;
        logic [31:0] n_drop;
        logic [31:0] n_len;
        logic [31:0] n_crc;
        logic [31:0] n_end;
        logic [31:0] n_ok;
    } t_parse_report;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_addr = CFG_START_BYTE;
    logic [7:0]   i_cfg_data = 8'h00;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;    // rx_byte[7:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // frame_length[7:0], payload_index[15:8], payload_byte[23:16],
    // discarded_count[55:24], length_error_count[87:56], crc_error_count[119:88],
    // framing_error_count[151:120], good_frame_count[183:152]
    logic [183:0] m_axis_tdata;
    logic [3:0]   m_axis_tuser;            // event_res[2:0], payload_write[3]

    stx_len_crc_frame_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // register shadow
    logic [7:0]  cfg_start = START_RESET;
    logic [7:0]  cfg_end   = END_RESET;
    logic [7:0]  cfg_max   = MAX_RESET;

    // parser state as the block should hold it
    t_phase      ph        = PH_IDLE;
    logic [7:0]  len_held  = 8'h00;
    logic [7:0]  wpos      = 8'h00;
    logic [15:0] crc_run   = CRC_INIT;
    logic [15:0] crc_rx    = 16'h0000;
    logic [31:0] cnt_drop  = '0;
    logic [31:0] cnt_len   = '0;
    logic [31:0] cnt_crc   = '0;
    logic [31:0] cnt_end   = '0;
    logic [31:0] cnt_ok    = '0;

    logic [7:0]    pending_bytes[$];
    logic [7:0]    frame_body[$];
    t_parse_report expected_reports[$];

    int  n_queued = 0;
    int  n_accepted = 0;
    int  n_checked = 0;
    int  n_mismatch = 0;
    int  n_settings = 1;
    int  src_wait = 0;
    int  snk_wait = 0;
    bit  src_gaps_on = 1'b1;
    bit  snk_gaps_on = 1'b1;
    logic hold_off = 1'b0;

    function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((v & CRC_MSB) != 0) begin
                v = (v << 1) ^ CRC_POLY;
            end else begin
                v = v << 1;
            end
        end
        return v;
    endfunction

    function automatic void predict_parse(logic [7:0] b);
        t_parse_report r;
        r = '0;
        r.ev = EV_NONE;
        case (ph)
            PH_LEN: begin
                if (b > cfg_max) begin
                    cnt_len++;
                    ph = PH_IDLE;
                    r.ev = EV_LENGTH;
                end else begin
                    len_held = b;
                    crc_run = crc16_step(crc_run, b);
                    ph = (b == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (int'(wpos) < BUF_DEPTH) begin
                    r.wr = 1'b1;
                    r.widx = wpos;
                    r.wbyte = b;
                end
                wpos++;
                crc_run = crc16_step(crc_run, b);
                if (wpos >= len_held) ph = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                crc_rx = {8'h00, b};
                ph = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                crc_rx[15:8] = b;
                if (crc_rx != crc_run) begin
                    cnt_crc++;
                    ph = PH_IDLE;
                    r.ev = EV_CRC;
                end else begin
                    ph = PH_END;
                end
            end
            PH_END: begin
                ph = PH_IDLE;
                if (b != cfg_end) begin
                    cnt_end++;
                    r.ev = EV_FRAMING;
                end else begin
                    cnt_ok++;
                    r.ev = EV_COMPLETE;
                end
            end
            default: begin
                if (b == cfg_start) begin
                    len_held = 8'h00;
                    wpos = 8'h00;
                    crc_run = CRC_INIT;
                    ph = PH_LEN;
                end else begin
                    cnt_drop++;
                end
            end
        endcase
        r.flen = len_held;
        r.n_drop = cnt_drop;
        r.n_len = cnt_len;
        r.n_crc = cnt_crc;
        r.n_end = cnt_end;
        r.n_ok = cnt_ok;
        expected_reports.push_back(r);
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap(bit on);
        int r;
        if (!on) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // byte source
    always @(posedge i_clk) begin : drv
        logic       nv;
        logic [7:0] nd;
        nv = s_axis_tvalid;
        nd = s_axis_tdata;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_parse(s_axis_tdata);
                n_accepted++;
                nv = 1'b0;
                src_wait = pick_gap(src_gaps_on);
            end
            if (!nv) begin
                if (src_wait > 0) begin
                    src_wait--;
                end else if (pending_bytes.size() > 0) begin
                    nv = 1'b1;
                    nd = pending_bytes.pop_front();
                end
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= nd;
    end

    // result sink and checker
    always @(posedge i_clk) begin : mon
        t_parse_report got;
        t_parse_report want;
        logic          rdy;
        rdy = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.ev     = t_event'(m_axis_tuser[2:0]);
                got.wr     = m_axis_tuser[3];
                got.flen   = m_axis_tdata[7:0];
                got.widx   = m_axis_tdata[15:8];
                got.wbyte  = m_axis_tdata[23:16];
                got.n_drop = m_axis_tdata[55:24];
                got.n_len  = m_axis_tdata[87:56];
                got.n_crc  = m_axis_tdata[119:88];
                got.n_end  = m_axis_tdata[151:120];
                got.n_ok   = m_axis_tdata[183:152];
                if (expected_reports.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("result with nothing expected: ev=%0d len=%0d",
                                 got.ev, got.flen);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.ev !== want.ev || got.flen !== want.flen || got.wr !== want.wr ||
                        got.widx !== want.widx || got.wbyte !== want.wbyte ||
                        got.n_drop !== want.n_drop || got.n_len !== want.n_len ||
                        got.n_crc !== want.n_crc || got.n_end !== want.n_end ||
                        got.n_ok !== want.n_ok) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("mismatch on result %0d", n_checked);
                            $display("  exp ev=%0d len=%0d wr=%0d idx=%0d byte=%h",
                                     want.ev, want.flen, want.wr, want.widx, want.wbyte);
                            $display("      cnt=%0d/%0d/%0d/%0d/%0d",
                                     want.n_drop, want.n_len, want.n_crc, want.n_end,
                                     want.n_ok);
                            $display("  got ev=%0d len=%0d wr=%0d idx=%0d byte=%h",
                                     got.ev, got.flen, got.wr, got.widx, got.wbyte);
                            $display("      cnt=%0d/%0d/%0d/%0d/%0d",
                                     got.n_drop, got.n_len, got.n_crc, got.n_end,
                                     got.n_ok);
                        end
                    end
                end
                n_checked++;
            end
            if (snk_wait > 0) begin
                snk_wait--;
            end else begin
                rdy = 1'b1;
                snk_wait = pick_gap(snk_gaps_on);
            end
        end
        m_axis_tready <= rdy && !hold_off;
    end

    // back-pressure: sink holds off once enough bytes are accepted and the source queue is full
    initial begin : pressure
        do @(posedge i_clk); while (n_accepted < 300 || pending_bytes.size() < 40);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic push_byte(logic [7:0] b);
        pending_bytes.push_back(b);
        n_queued++;
    endtask

    // start, length, frame_body, crc, end, with optional damage
    task automatic queue_frame(t_frame_kind kind);
        logic [15:0] crc;
        logic [7:0]  len;
        int          keep;
        len = 8'(frame_body.size());
        push_byte(cfg_start);
        push_byte(len);
        if (kind == FR_CUT) begin
            keep = (len == 0) ? 0 : $urandom_range(0, len - 1);
            for (int i = 0; i < keep; i++) push_byte(frame_body[i]);
        end else begin
            crc = crc16_step(CRC_INIT, len);
            foreach (frame_body[i]) begin
                crc = crc16_step(crc, frame_body[i]);
                push_byte(frame_body[i]);
            end
            if (kind == FR_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
            push_byte(crc[7:0]);
            push_byte(crc[15:8]);
            if (kind == FR_BAD_END) push_byte(cfg_end ^ 8'($urandom_range(1, 255)));
            else push_byte(cfg_end);
        end
    endtask

    task automatic fill_body(int n);
        frame_body.delete();
        repeat (n) frame_body.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_random_frame();
        int pick;
        int sel;
        int n;
        pick = $urandom_range(0, 99);
        sel = $urandom_range(0, 99);
        if (sel < 8 && cfg_max <= 64) n = cfg_max;
        else if (sel < 11) n = $urandom_range(0, cfg_max);
        else n = $urandom_range(0, (cfg_max < 8) ? cfg_max : 8);
        fill_body(n);
        if (pick < 62) begin
            queue_frame(FR_GOOD);
        end else if (pick < 70) begin
            queue_frame(FR_BAD_CRC);
        end else if (pick < 78) begin
            queue_frame(FR_BAD_END);
        end else if (pick < 84) begin
            if (cfg_max < 8'hFF) begin
                push_byte(cfg_start);
                push_byte(8'($urandom_range(cfg_max + 1, 255)));
            end else begin
                queue_frame(FR_GOOD);
            end
        end else if (pick < 90) begin
            queue_frame(FR_CUT);
        end else begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(int target);
        int base;
        base = n_queued;
        while (n_queued - base < target) add_random_frame();
    endtask

    task automatic wait_drain();
        do @(posedge i_clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [7:0] sb, logic [7:0] eb, logic [7:0] mp);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_START_BYTE;
        i_cfg_data <= sb;
        @(posedge i_clk);
        i_cfg_addr <= CFG_END_BYTE;
        i_cfg_data <= eb;
        @(posedge i_clk);
        i_cfg_addr <= CFG_MAX_PAYLOAD;
        i_cfg_data <= mp;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_start = sb;
        cfg_end = eb;
        cfg_max = mp;
        n_settings++;
    endtask

    initial begin : seq
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: hunting bytes, empty frame, oversize, bad crc, bad end, extreme payload
        push_byte(8'h00);
        push_byte(8'hFF);
        fill_body(0);
        queue_frame(FR_GOOD);
        push_byte(cfg_start);
        push_byte(8'hFF);
        frame_body.delete();
        frame_body.push_back(8'hAA);
        queue_frame(FR_BAD_CRC);
        fill_body(0);
        queue_frame(FR_BAD_END);
        frame_body.delete();
        frame_body.push_back(8'h00);
        frame_body.push_back(8'hFF);
        queue_frame(FR_GOOD);
        run_random(180);
        wait_drain();

        // only empty frames fit
        set_regs(8'hFF, 8'h00, 8'h00);
        src_gaps_on = 1'b0;
        snk_gaps_on = 1'b0;
        run_random(180);
        wait_drain();

        // widest length, one full-size frame
        set_regs(8'h00, 8'hFF, 8'hFF);
        src_gaps_on = 1'b1;
        fill_body(255);
        queue_frame(FR_GOOD);
        run_random(150);
        wait_drain();

        for (int i = 0; i < 3; i++) begin
            set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     (i == 0) ? 8'd1 : 8'($urandom_range(2, 20)));
            src_gaps_on = 1'($urandom_range(0, 1));
            snk_gaps_on = 1'($urandom_range(0, 1));
            run_random(190);
            wait_drain();
        end

        $display("sent %0d bytes under %0d register settings, %0d results checked",
                 n_accepted, n_settings, n_checked);
        $display("frames: %0d good, %0d crc, %0d length, %0d end-byte errors; %0d bytes dropped",
                 cnt_ok, cnt_crc, cnt_len, cnt_end, cnt_drop);
        if (n_mismatch == 0 && expected_reports.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
